[hw/rtl/fcwd_pkg.sv]
`default_nettype none

package fcwd_pkg;

  localparam int MAX_WORD_LEN = 16;
  localparam int ADDR_W       = $clog2(MAX_WORD_LEN);
  localparam int WPOS_W       = $clog2(MAX_WORD_LEN + 1);

  localparam int CHAR_W = 8;
  localparam int POS_W  = 4;
  localparam int LEN_W  = 5;

  localparam logic [CHAR_W-1:0] LETTER_A = 8'd97;
  localparam logic [CHAR_W-1:0] LETTER_Q = 8'd113;
  localparam logic [CHAR_W-1:0] LETTER_U = 8'd117;

  // write port of the word store
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [CHAR_W-1:0] data;
  } fcwd_wr_t;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_PUT_U = 4'b0010,
    ST_READ  = 4'b0100,
    ST_SHOW  = 4'b1000
  } fcwd_state_t;

endpackage

`default_nettype wire

[hw/rtl/front_coded_word_decoder.sv]
`default_nettype none
// Channel | Ports                                            | Transfer when
// input   | in_code_byte, in_end_of_dict                     | in_valid & !in_stall
// output  | out_letter, out_position, out_word_length,       | out_valid & !out_stall
//         | out_last_letter, out_overflowed                  |
// A 'q' letter byte also writes an added 'u' as a second store write (state ST_PUT_U).
// A count byte or end-of-dictionary that closes a word reads its letters back in order:
// each letter is one registered store read (ST_READ), then shown on the output (ST_SHOW).
// Input is taken only in ST_IDLE, not while a 'u' is added or a word is read out; out_stall holds the current letter.
// Reset is synchronous; store entries read as zero until written, with no clearing pass.

module front_coded_word_decoder (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [fcwd_pkg::CHAR_W-1:0]  in_code_byte,
  input  wire logic                         in_end_of_dict,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [fcwd_pkg::CHAR_W-1:0]       out_letter,
  output logic [fcwd_pkg::POS_W-1:0]        out_position,
  output logic [fcwd_pkg::LEN_W-1:0]        out_word_length,
  output logic                              out_last_letter,
  output logic                              out_overflowed
);
  import fcwd_pkg::*;

  fcwd_state_t       state_r, state_nxt;
  logic [WPOS_W-1:0] wp_r, wp_nxt;
  logic              pending_r, pending_nxt;
  logic              ovf_r, ovf_nxt;
  logic [WPOS_W-1:0] emit_len_r, emit_len_nxt;
  logic              emit_ovf_r, emit_ovf_nxt;
  logic [ADDR_W-1:0] idx_r, idx_nxt;

  fcwd_wr_t          wr;
  logic [CHAR_W-1:0] rd_data;
  logic              in_xfer, out_xfer, is_last, store_full, has_word;
  logic [WPOS_W-1:0] idx_plus1;

  fcwd_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (wr),
    .rd_addr (idx_r),
    .rd_data (rd_data)
  );

  assign in_stall   = (state_r != ST_IDLE);
  assign in_xfer    = in_valid && !in_stall;
  assign out_valid  = (state_r == ST_SHOW);
  assign out_xfer   = out_valid && !out_stall;
  assign idx_plus1  = WPOS_W'(idx_r) + WPOS_W'(1);
  assign is_last    = (idx_plus1 == emit_len_r);
  assign store_full = (wp_r >= WPOS_W'(MAX_WORD_LEN));
  assign has_word   = pending_r && (wp_r != '0);

  assign out_letter      = rd_data;
  assign out_position    = POS_W'(idx_r);
  assign out_word_length = LEN_W'(emit_len_r);
  assign out_last_letter = is_last;
  assign out_overflowed  = emit_ovf_r;

  always_comb begin
    state_nxt    = state_r;
    wp_nxt       = wp_r;
    pending_nxt  = pending_r;
    ovf_nxt      = ovf_r;
    emit_len_nxt = emit_len_r;
    emit_ovf_nxt = emit_ovf_r;
    idx_nxt      = idx_r;
    wr.en        = 1'b0;
    wr.addr      = wp_r[ADDR_W-1:0];
    wr.data      = in_code_byte;

    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          if (in_end_of_dict || in_code_byte < LETTER_A) begin
            // close the word being built
            if (has_word) begin
              emit_len_nxt = wp_r;
              emit_ovf_nxt = ovf_r;
              idx_nxt      = '0;
              state_nxt    = ST_READ;
            end
            if (in_end_of_dict) begin
              wp_nxt      = '0;
              pending_nxt = 1'b0;
              ovf_nxt     = 1'b0;
            end else begin
              pending_nxt = 1'b1;
              if (in_code_byte > CHAR_W'(MAX_WORD_LEN)) begin
                wp_nxt  = WPOS_W'(MAX_WORD_LEN);
                ovf_nxt = 1'b1;
              end else begin
                wp_nxt  = WPOS_W'(in_code_byte);
                ovf_nxt = 1'b0;
              end
            end
          end else begin
            pending_nxt = 1'b1;
            if (store_full) begin
              ovf_nxt = 1'b1;
            end else begin
              wr.en  = 1'b1;
              wp_nxt = wp_r + WPOS_W'(1);
            end
            if (in_code_byte == LETTER_Q) begin
              state_nxt = ST_PUT_U;
            end
          end
        end
      end
      ST_PUT_U: begin
        wr.data = LETTER_U;
        if (store_full) begin
          ovf_nxt = 1'b1;
        end else begin
          wr.en  = 1'b1;
          wp_nxt = wp_r + WPOS_W'(1);
        end
        state_nxt = ST_IDLE;
      end
      ST_READ: begin
        state_nxt = ST_SHOW;
      end
      ST_SHOW: begin
        if (out_xfer) begin
          if (is_last) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt   = idx_r + ADDR_W'(1);
            state_nxt = ST_READ;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      wp_r      <= '0;
      pending_r <= 1'b0;
      ovf_r     <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      wp_r      <= wp_nxt;
      pending_r <= pending_nxt;
      ovf_r     <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    emit_len_r <= emit_len_nxt;
    emit_ovf_r <= emit_ovf_nxt;
    idx_r      <= idx_nxt;
  end

endmodule

`default_nettype wire

[hw/rtl/fcwd_store.sv]
`default_nettype none

module fcwd_store (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire fcwd_pkg::fcwd_wr_t        wr,
  input  wire logic [fcwd_pkg::ADDR_W-1:0] rd_addr,
  output logic [fcwd_pkg::CHAR_W-1:0]    rd_data
);
  import fcwd_pkg::*;

  logic [CHAR_W-1:0]       mem [MAX_WORD_LEN];
  logic [MAX_WORD_LEN-1:0] vld_r;
  logic [CHAR_W-1:0]       rd_data_r;
  logic                    rd_vld_r;

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr.en) begin
      vld_r[wr.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
    rd_vld_r  <= vld_r[rd_addr];
  end

  assign rd_data = rd_vld_r ? rd_data_r : '0;

endmodule

`default_nettype wire

[sim/fcwd_checker.sv]
`timescale 1ns / 1ps

module fcwd_checker (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  input  wire logic                        in_stall,
  input  wire logic [fcwd_pkg::CHAR_W-1:0] in_code_byte,
  input  wire logic                        in_end_of_dict,
  input  wire logic                        out_valid,
  input  wire logic                        out_stall,
  input  wire logic [fcwd_pkg::CHAR_W-1:0] out_letter,
  input  wire logic [fcwd_pkg::POS_W-1:0]  out_position,
  input  wire logic [fcwd_pkg::LEN_W-1:0]  out_word_length,
  input  wire logic                        out_last_letter,
  input  wire logic                        out_overflowed,
  output int                               mismatches,
  output int                               letters_due
);
  import fcwd_pkg::*;

  typedef struct packed {
    logic [CHAR_W-1:0] letter;
    logic [POS_W-1:0]  position;
    logic [LEN_W-1:0]  word_length;
    logic              last_letter;
    logic              overflowed;
  } letter_rec_t;

  letter_rec_t       due_q[$];
  logic [CHAR_W-1:0] word_mem[MAX_WORD_LEN];
  int unsigned       wr_pos;
  bit                word_open;
  bit                word_ovf;
  int                reported;

  // queue every letter of the word being closed
  task automatic close_word();
    int unsigned len;
    letter_rec_t rec;
    len = (wr_pos > MAX_WORD_LEN) ? MAX_WORD_LEN : wr_pos;
    if (word_open && len != 0) begin
      for (int unsigned i = 0; i < len; i++) begin
        rec.letter      = word_mem[i];
        rec.position    = POS_W'(i);
        rec.word_length = LEN_W'(len);
        rec.last_letter = (i + 1 == len);
        rec.overflowed  = word_ovf;
        due_q.push_back(rec);
      end
    end
  endtask

  task automatic store_char(input logic [CHAR_W-1:0] ch);
    if (wr_pos < MAX_WORD_LEN) begin
      word_mem[wr_pos] = ch;
      wr_pos++;
    end else begin
      word_ovf = 1'b1;
    end
  endtask

  task automatic note_mismatch(input letter_rec_t want, input letter_rec_t got);
    mismatches++;
    if (reported < 10) begin
      reported++;
      $display("%0t: letter mismatch: expected %h pos %0d len %0d last %b ovf %b,",
               $realtime, want.letter, want.position, want.word_length,
               want.last_letter, want.overflowed);
      $display("    got %h pos %0d len %0d last %b ovf %b",
               got.letter, got.position, got.word_length, got.last_letter,
               got.overflowed);
    end
  endtask

  always @(posedge clk) begin
    letter_rec_t got;
    letter_rec_t want;
    if (!rst_n) begin
      due_q.delete();
      foreach (word_mem[i]) word_mem[i] = '0;
      wr_pos      = 0;
      word_open   = 1'b0;
      word_ovf    = 1'b0;
      mismatches  = 0;
      reported    = 0;
      letters_due = 0;
    end else begin
      // output side first: a letter leaving now belongs to an earlier transfer
      if (out_valid && !out_stall) begin
        got.letter      = out_letter;
        got.position    = out_position;
        got.word_length = out_word_length;
        got.last_letter = out_last_letter;
        got.overflowed  = out_overflowed;
        if (due_q.size() == 0) begin
          mismatches++;
          if (reported < 10) begin
            reported++;
            $display("%0t: letter %h pos %0d arrived with nothing due",
                     $realtime, got.letter, got.position);
          end
        end else begin
          want = due_q.pop_front();
          if (got.letter !== want.letter || got.position !== want.position ||
              got.word_length !== want.word_length ||
              got.last_letter !== want.last_letter ||
              got.overflowed !== want.overflowed)
            note_mismatch(want, got);
        end
      end

      if (in_valid && !in_stall) begin
        if (in_end_of_dict) begin
          close_word();
          word_open = 1'b0;
          word_ovf  = 1'b0;
          wr_pos    = 0;
        end else if (in_code_byte < LETTER_A) begin
          close_word();
          if (in_code_byte > MAX_WORD_LEN) begin
            wr_pos   = MAX_WORD_LEN;
            word_ovf = 1'b1;
          end else begin
            wr_pos   = in_code_byte;
            word_ovf = 1'b0;
          end
          word_open = 1'b1;
        end else begin
          word_open = 1'b1;
          store_char(in_code_byte);
          if (in_code_byte == LETTER_Q) store_char(LETTER_U);
        end
      end
      letters_due = due_q.size();
    end
  end

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import fcwd_pkg::*;

  logic              clk             = 1'b0;
  logic              rst_n           = 1'b0;
  logic              in_valid        = 1'b0;
  logic              in_stall;
  logic [CHAR_W-1:0] in_code_byte    = '0;
  logic              in_end_of_dict  = 1'b0;
  logic              out_valid;
  logic              out_stall       = 1'b0;
  logic [CHAR_W-1:0] out_letter;
  logic [POS_W-1:0]  out_position;
  logic [LEN_W-1:0]  out_word_length;
  logic              out_last_letter;
  logic              out_overflowed;

  int mismatches;
  int letters_due;
  int bytes_sent;
  bit quiet;
  bit hold_req;

  always #6 clk = ~clk;

  front_coded_word_decoder u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_code_byte    (in_code_byte),
    .in_end_of_dict  (in_end_of_dict),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_letter      (out_letter),
    .out_position    (out_position),
    .out_word_length (out_word_length),
    .out_last_letter (out_last_letter),
    .out_overflowed  (out_overflowed)
  );

  fcwd_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_code_byte    (in_code_byte),
    .in_end_of_dict  (in_end_of_dict),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_letter      (out_letter),
    .out_position    (out_position),
    .out_word_length (out_word_length),
    .out_last_letter (out_last_letter),
    .out_overflowed  (out_overflowed),
    .mismatches      (mismatches),
    .letters_due     (letters_due)
  );

  // one transfer, then maybe a gap; valid stays up when no gap follows
  task automatic push_byte(input logic [CHAR_W-1:0] code, input logic eod);
    in_valid       <= 1'b1;
    in_code_byte   <= code;
    in_end_of_dict <= eod;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  task automatic push_letter();
    logic [CHAR_W-1:0] ch;
    case ($urandom_range(0, 7))
      0:       ch = LETTER_Q;
      1:       ch = CHAR_W'($urandom_range(LETTER_A, 255));
      default: ch = CHAR_W'($urandom_range(LETTER_A, LETTER_A + 25));
    endcase
    push_byte(ch, 1'b0);
  endtask

  // prefix count followed by a run of letters
  task automatic push_word();
    int n;
    if ($urandom_range(0, 9) == 0)
      push_byte(CHAR_W'($urandom_range(MAX_WORD_LEN + 1, LETTER_A - 1)), 1'b0);
    else
      push_byte(CHAR_W'($urandom_range(0, MAX_WORD_LEN)), 1'b0);
    n = ($urandom_range(0, 7) == 0) ? $urandom_range(12, 20) : $urandom_range(0, 6);
    repeat (n) push_letter();
  endtask

  // output side: random stall bursts, one long hold-off on request
  initial begin
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
      end else if (quiet) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(0, 2) == 0);
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("front_coded_word_decoder verification failed");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // letter with no count yet, then q with its implied u
    push_byte(CHAR_W'(LETTER_A + 1), 1'b0);
    push_byte(LETTER_Q, 1'b0);
    push_byte(8'd0, 1'b0);
    push_byte(8'd0, 1'b0);          // empty word
    push_byte(8'hFF, 1'b0);
    push_byte(LETTER_A, 1'b0);
    push_byte(8'd1, 1'b0);
    push_byte(CHAR_W'(LETTER_A - 1), 1'b0);  // largest count, saturates
    push_byte(8'd120, 1'b0);        // dropped, store full
    push_byte(CHAR_W'(MAX_WORD_LEN), 1'b0);
    push_byte(LETTER_Q, 1'b0);      // q and u both dropped
    push_byte(8'hFF, 1'b1);
    push_byte(8'd0, 1'b1);          // nothing pending
    push_byte(CHAR_W'(MAX_WORD_LEN - 1), 1'b0);
    push_byte(LETTER_Q, 1'b0);      // u falls off the end
    push_byte(CHAR_W'(MAX_WORD_LEN + 1), 1'b0);
    push_byte(CHAR_W'(MAX_WORD_LEN - 2), 1'b0);
    push_byte(LETTER_Q, 1'b0);
    push_byte(8'd122, 1'b1);
    push_byte(8'h80, 1'b0);
    push_byte(8'h7F, 1'b0);
    push_byte(8'd2, 1'b0);
    push_byte(8'd0, 1'b1);

    hold_req   = 1'b1;
    while (bytes_sent < 170) begin
      if (bytes_sent >= 140) quiet = 1'b1;
      case ($urandom_range(0, 19))
        0:       push_byte(CHAR_W'($urandom_range(0, 255)), 1'b1);
        1:       push_byte(CHAR_W'($urandom_range(0, 255)), 1'b0);
        default: push_word();
      endcase
    end
    push_byte(CHAR_W'($urandom_range(0, 255)), 1'b1);
    quiet = 1'b1;
    in_valid <= 1'b0;

    @(posedge clk);
    while (letters_due != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    if (mismatches == 0 && letters_due == 0) begin
      $display("front_coded_word_decoder verification clean");
    end else begin
      if (letters_due != 0) $display("%0d letters never arrived", letters_due);
      $display("front_coded_word_decoder verification failed");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/fcwd_pkg.sv
hw/rtl/fcwd_store.sv
hw/rtl/front_coded_word_decoder.sv
sim/fcwd_checker.sv
sim/tb_top.sv
